/* rtl/core/positional_list_engine_macros.svh */
// Assertion helpers shared by the list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PLE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("list engine check failed");

// Next-cycle implication, disabled during reset.
`define PLE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("list engine check failed");

`endif

/* rtl/core/ple_pkg.sv */
package ple_pkg;

   localparam int CAPACITY = 16;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int POS_W    = 5;
   localparam int CMP_W    = ((COUNT_W > POS_W) ? COUNT_W : POS_W) + 1;

   typedef logic [2:0]         mode_type;
   typedef logic signed [31:0] value_type;
   typedef logic [POS_W-1:0]   position_type;
   typedef logic [1:0]         status_type;
   typedef logic [4:0]         count_field_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [IDX_W-1:0]   index_type;
   typedef logic [CMP_W-1:0]   compare_type;

   localparam mode_type MODE_CREATE       = 3'd0;
   localparam mode_type MODE_INSERT_FRONT = 3'd1;
   localparam mode_type MODE_INSERT_END   = 3'd2;
   localparam mode_type MODE_INSERT_AT    = 3'd3;
   localparam mode_type MODE_DELETE_FRONT = 3'd4;
   localparam mode_type MODE_DELETE_END   = 3'd5;
   localparam mode_type MODE_DELETE_AT    = 3'd6;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_EMPTY = 2'd2;
   localparam status_type ST_RANGE = 2'd3;

endpackage

/* rtl/core/ple_channels.sv */
interface ple_req_if import ple_pkg::*; ();
   logic         valid;
   logic         ready;
   mode_type     mode;
   value_type    value;
   position_type position;

   modport source (output valid, output mode, output value, output position, input ready);
   modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

interface ple_rsp_if import ple_pkg::*; ();
   logic            valid;
   logic            ready;
   status_type      status;
   count_field_type count;
   logic            is_empty;
   value_type       middle_value;

   modport source (output valid, output status, output count, output is_empty,
                   output middle_value, input ready);
   modport sink   (input valid, input status, input count, input is_empty,
                   input middle_value, output ready);
endinterface

/* rtl/core/positional_list_engine.sv */
// Ordered list of up to CAPACITY signed 32-bit values with front, end and
// positional insert/delete. Each request beat is latched into an input
// register; when the result register is free or being taken, one pass of
// logic shifts the cells from the operation index onward by one place in
// parallel, updates the count and loads the result register. A new request
// can be taken every cycle while results are taken (one item per cycle, set
// by the single shift pass across the cell array). Results stall only when
// the result register is full and not being taken. The cell array needs no
// clearing after reset; only the count and the valid flags are cleared.
// Errors (full, empty, position out of range) leave the list untouched and
// are reported in the status field.
`include "positional_list_engine_macros.svh"

module positional_list_engine import ple_pkg::*; (
   input logic        clock,
   input logic        reset,
   ple_req_if.sink    req_chan,
   ple_rsp_if.source  rsp_chan
);

   logic         in_valid_ff, in_valid_in;
   mode_type     in_mode_ff;
   value_type    in_value_ff;
   position_type in_pos_ff;

   value_type    cells_ff [CAPACITY];
   value_type    cells_in [CAPACITY];
   count_type    count_ff, count_in;

   logic            rsp_valid_ff, rsp_valid_in;
   status_type      rsp_status_ff, status_in;
   count_field_type rsp_count_ff;
   logic            rsp_empty_ff;
   value_type       rsp_mid_ff, mid_in;

   logic        advance;
   logic        do_ins, do_del;
   index_type   op_idx, mid_idx;
   count_type   base_cnt;
   compare_type pos_ext, cnt_ext;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign in_valid_in  = req_chan.valid ? 1'b1 : (in_valid_ff && !advance);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);

   assign pos_ext = compare_type'(in_pos_ff);
   assign cnt_ext = compare_type'(count_ff);

   // decode the operation
   always_comb begin
      do_ins    = 1'b0;
      do_del    = 1'b0;
      op_idx    = '0;
      status_in = ST_OK;
      base_cnt  = count_ff;
      unique case (in_mode_ff)
         MODE_CREATE: begin
            do_ins   = 1'b1;
            base_cnt = '0;
         end
         MODE_INSERT_FRONT, MODE_INSERT_END, MODE_INSERT_AT: begin
            if (count_ff == count_type'(CAPACITY)) begin
               status_in = ST_FULL;
            end else if (in_mode_ff == MODE_INSERT_FRONT) begin
               do_ins = 1'b1;
            end else if (in_mode_ff == MODE_INSERT_END) begin
               do_ins = 1'b1;
               op_idx = index_type'(count_ff);
            end else if (in_pos_ff == '0 || pos_ext > cnt_ext + compare_type'(1)) begin
               status_in = ST_RANGE;
            end else begin
               do_ins = 1'b1;
               op_idx = index_type'(pos_ext - compare_type'(1));
            end
         end
         MODE_DELETE_FRONT, MODE_DELETE_END, MODE_DELETE_AT: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else if (in_mode_ff == MODE_DELETE_FRONT) begin
               do_del = 1'b1;
            end else if (in_mode_ff == MODE_DELETE_END) begin
               do_del = 1'b1;
               op_idx = index_type'(count_ff - count_type'(1));
            end else if (in_pos_ff == '0 || pos_ext > cnt_ext) begin
               status_in = ST_RANGE;
            end else begin
               do_del = 1'b1;
               op_idx = index_type'(pos_ext - compare_type'(1));
            end
         end
         default: begin
         end
      endcase
   end

   // shift the cells from the operation index onward one place in parallel
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_in[i] = cells_ff[i];
         if (do_ins) begin
            if (index_type'(i) == op_idx) begin
               cells_in[i] = in_value_ff;
            end else if (index_type'(i) > op_idx) begin
               cells_in[i] = cells_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (do_del && index_type'(i) >= op_idx && i < CAPACITY - 1) begin
            cells_in[i] = cells_ff[i + 1];
         end
      end
   end

   always_comb begin
      if (do_ins) begin
         count_in = base_cnt + count_type'(1);
      end else if (do_del) begin
         count_in = count_ff - count_type'(1);
      end else begin
         count_in = count_ff;
      end
      mid_idx = index_type'((count_in - count_type'(1)) >> 1);
      mid_in  = (count_in == '0) ? '0 : cells_in[mid_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_mode_ff  <= req_chan.mode;
         in_value_ff <= req_chan.value;
         in_pos_ff   <= req_chan.position;
      end
      if (advance) begin
         cells_ff      <= cells_in;
         rsp_status_ff <= status_in;
         rsp_count_ff  <= count_field_type'(count_in);
         rsp_empty_ff  <= (count_in == '0);
         rsp_mid_ff    <= mid_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.count        = rsp_count_ff;
   assign rsp_chan.is_empty     = rsp_empty_ff;
   assign rsp_chan.middle_value = rsp_mid_ff;

   `PLE_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= count_type'(CAPACITY))
   `PLE_ASSERT_NEXT(a_error_holds_count, clock, reset,
      advance && status_in != ST_OK, $stable(count_ff))
   `PLE_ASSERT_NEXT(a_insert_grows, clock, reset,
      advance && do_ins && in_mode_ff != MODE_CREATE,
      count_ff == $past(count_ff) + count_type'(1))
   `PLE_ASSERT_NEXT(a_result_tracks_count, clock, reset,
      advance, rsp_count_ff == count_field_type'(count_ff))

endmodule
